### src/rrht_pkg.sv
package rrht_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned WIDTH_BITS     = 15;
  localparam int unsigned HEIGHT_BITS    = 15;
  localparam int unsigned RADIUS_BITS    = 14;
  localparam int unsigned SQ_BITS        = 2 * RADIUS_BITS;
  localparam int unsigned CFG_INDEX_BITS = 3;

  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned CORNER_BL   = 0;
  localparam int unsigned CORNER_BR   = 1;
  localparam int unsigned CORNER_TL   = 2;
  localparam int unsigned CORNER_TR   = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RECT_X        = 3'd0,
    REG_RECT_Y        = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                   box_hit;
    logic [NUM_CORNERS-1:0] disc_en;
    logic [RADIUS_BITS-1:0] mag_xl;
    logic [RADIUS_BITS-1:0] mag_xr;
    logic [RADIUS_BITS-1:0] mag_yb;
    logic [RADIUS_BITS-1:0] mag_yt;
    logic [RADIUS_BITS-1:0] radius;
  } loc_t;

endpackage

### src/rrht_cfg.sv
module rrht_cfg import rrht_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned DATA_BITS  = (COORD_BITS > 16) ? COORD_BITS : 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [DATA_BITS-1:0]         cfg_data_i,
  output logic signed [COORD_BITS-1:0] rect_x_o,
  output logic signed [COORD_BITS-1:0] rect_y_o,
  output logic [WIDTH_BITS-1:0]        rect_width_o,
  output logic [HEIGHT_BITS-1:0]       rect_height_o,
  output logic [RADIUS_BITS-1:0]       corner_radius_o
);

  logic signed [COORD_BITS-1:0] rect_x_q, rect_y_q;
  logic [WIDTH_BITS-1:0]        rect_width_q;
  logic [HEIGHT_BITS-1:0]       rect_height_q;
  logic [RADIUS_BITS-1:0]       corner_radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_x_q        <= '0;
      rect_y_q        <= '0;
      rect_width_q    <= '0;
      rect_height_q   <= '0;
      corner_radius_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RECT_X:        rect_x_q        <= cfg_data_i[COORD_BITS-1:0];
        REG_RECT_Y:        rect_y_q        <= cfg_data_i[COORD_BITS-1:0];
        REG_RECT_WIDTH:    rect_width_q    <= cfg_data_i[WIDTH_BITS-1:0];
        REG_RECT_HEIGHT:   rect_height_q   <= cfg_data_i[HEIGHT_BITS-1:0];
        REG_CORNER_RADIUS: corner_radius_q <= cfg_data_i[RADIUS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign rect_x_o        = rect_x_q;
  assign rect_y_o        = rect_y_q;
  assign rect_width_o    = rect_width_q;
  assign rect_height_o   = rect_height_q;
  assign corner_radius_o = corner_radius_q;

endmodule

### src/rrht_locate.sv
module rrht_locate import rrht_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         s1_en_i,
  input  logic                         s2_en_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] rect_x_i,
  input  logic signed [COORD_BITS-1:0] rect_y_i,
  input  logic [WIDTH_BITS-1:0]        rect_width_i,
  input  logic [HEIGHT_BITS-1:0]       rect_height_i,
  input  logic [RADIUS_BITS-1:0]       corner_radius_i,
  output loc_t                         loc_o
);

  localparam int unsigned MAX_BITS = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int unsigned EW       = MAX_BITS + 3;

  typedef enum logic [2:0] {
    MODE_BOX,
    MODE_CIRCLE,
    MODE_HSTAD,
    MODE_VSTAD,
    MODE_ROUND
  } shape_mode_e;

  function automatic logic signed [EW-1:0] abs_val(input logic signed [EW-1:0] d);
    return d[EW-1] ? -d : d;
  endfunction

  logic signed [EW-1:0] x_e, y_e, w_e, h_e, r_e, r2_e;
  logic [WIDTH_BITS-1:0] two_r;
  shape_mode_e           mode_d, mode_q;

  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic signed [EW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic signed [EW-1:0] cxl_q, cxr_q, cyb_q, cyt_q;
  logic signed [EW-1:0] wh_q, hw_q, wc_q, hc_q;
  logic [RADIUS_BITS-1:0] rad_q;

  assign x_e   = EW'(rect_x_i);
  assign y_e   = EW'(rect_y_i);
  assign w_e   = EW'(rect_width_i);
  assign h_e   = EW'(rect_height_i);
  assign r_e   = EW'(corner_radius_i);
  assign r2_e  = EW'({corner_radius_i, 1'b0});
  assign two_r = {corner_radius_i, 1'b0};

  always_comb begin
    priority if (corner_radius_i == '0) begin
      mode_d = MODE_BOX;
    end else if (two_r == rect_height_i && rect_height_i == rect_width_i) begin
      mode_d = MODE_CIRCLE;
    end else if (two_r == rect_height_i) begin
      mode_d = MODE_HSTAD;
    end else if (two_r == rect_width_i) begin
      mode_d = MODE_VSTAD;
    end else begin
      mode_d = MODE_ROUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en_i) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      x0_q   <= x_e;
      x1_q   <= x_e + w_e;
      y0_q   <= y_e;
      y1_q   <= y_e + h_e;
      cxl_q  <= x_e + r_e;
      cxr_q  <= x_e + w_e - r_e;
      cyb_q  <= y_e + r_e;
      cyt_q  <= y_e + h_e - r_e;
      wh_q   <= w_e - h_e;
      hw_q   <= h_e - w_e;
      wc_q   <= w_e - r2_e;
      hc_q   <= h_e - r2_e;
      rad_q  <= corner_radius_i;
      mode_q <= mode_d;
    end
  end

  logic signed [EW-1:0] px_e, py_e, rad_e;
  logic signed [EW-1:0] dxl, dxr, dyb, dyt;
  logic signed [EW-1:0] axl, axr, ayb, ayt;
  logic near_xl, near_xr, near_yb, near_yt;
  logic in_x, in_y, box_plain, box_h, box_v, box_c, box_l, box_r;
  logic cl, cr, cb, ct;
  loc_t loc_d, loc_q;

  assign px_e  = EW'(px_q);
  assign py_e  = EW'(py_q);
  assign rad_e = EW'(rad_q);

  assign dxl = px_e - cxl_q;
  assign dxr = px_e - cxr_q;
  assign dyb = py_e - cyb_q;
  assign dyt = py_e - cyt_q;

  assign axl = abs_val(dxl);
  assign axr = abs_val(dxr);
  assign ayb = abs_val(dyb);
  assign ayt = abs_val(dyt);

  assign near_xl = axl <= rad_e;
  assign near_xr = axr <= rad_e;
  assign near_yb = ayb <= rad_e;
  assign near_yt = ayt <= rad_e;

  assign in_x      = px_e >= x0_q && px_e <= x1_q;
  assign in_y      = py_e >= y0_q && py_e <= y1_q;
  assign box_plain = in_x && in_y;
  assign box_h     = !dxl[EW-1] && dxl <= wh_q && in_y;
  assign box_v     = in_x && !dyb[EW-1] && dyb <= hw_q;
  assign box_c     = !dxl[EW-1] && dxl <= wc_q && in_y;
  assign box_l     = px_e >= x0_q && (dxl[EW-1] || dxl == '0)
                     && !dyb[EW-1] && dyb <= hc_q;
  assign box_r     = !dxr[EW-1] && dxr <= rad_e && !dyb[EW-1] && dyb <= hc_q;

  assign cl = dxl[EW-1];
  assign cr = !dxr[EW-1] && dxr != '0;
  assign cb = dyb[EW-1];
  assign ct = !dyt[EW-1] && dyt != '0;

  always_comb begin
    loc_d         = '0;
    loc_d.mag_xl  = axl[RADIUS_BITS-1:0];
    loc_d.mag_xr  = axr[RADIUS_BITS-1:0];
    loc_d.mag_yb  = ayb[RADIUS_BITS-1:0];
    loc_d.mag_yt  = ayt[RADIUS_BITS-1:0];
    loc_d.radius  = rad_q;
    unique case (mode_q)
      MODE_BOX: begin
        loc_d.box_hit = box_plain;
      end
      MODE_CIRCLE: begin
        loc_d.disc_en[CORNER_BL] = 1'b1;
      end
      MODE_HSTAD: begin
        loc_d.box_hit            = box_h;
        loc_d.disc_en[CORNER_BL] = cl;
        loc_d.disc_en[CORNER_BR] = cr;
      end
      MODE_VSTAD: begin
        loc_d.box_hit            = box_v;
        loc_d.disc_en[CORNER_BL] = cb;
        loc_d.disc_en[CORNER_TL] = ct;
      end
      MODE_ROUND: begin
        loc_d.box_hit            = box_c || box_l || box_r;
        loc_d.disc_en[CORNER_BL] = cl && cb;
        loc_d.disc_en[CORNER_TL] = cl && ct;
        loc_d.disc_en[CORNER_BR] = cr && cb;
        loc_d.disc_en[CORNER_TR] = cr && ct;
      end
      default: begin
      end
    endcase
    loc_d.disc_en[CORNER_BL] = loc_d.disc_en[CORNER_BL] && near_xl && near_yb;
    loc_d.disc_en[CORNER_BR] = loc_d.disc_en[CORNER_BR] && near_xr && near_yb;
    loc_d.disc_en[CORNER_TL] = loc_d.disc_en[CORNER_TL] && near_xl && near_yt;
    loc_d.disc_en[CORNER_TR] = loc_d.disc_en[CORNER_TR] && near_xr && near_yt;
  end

  always_ff @(posedge clk_i) begin
    if (s2_en_i) begin
      loc_q <= loc_d;
    end
  end

  assign loc_o = loc_q;

endmodule

### src/rrht_disc.sv
module rrht_disc import rrht_pkg::*; (
  input  logic clk_i,
  input  logic s3_en_i,
  input  logic s4_en_i,
  input  loc_t loc_i,
  output logic inside_o
);

  logic [SQ_BITS-1:0]     sq_xl_q, sq_xr_q, sq_yb_q, sq_yt_q, rsq_q;
  logic                   box_q;
  logic [NUM_CORNERS-1:0] en_q;

  always_ff @(posedge clk_i) begin
    if (s3_en_i) begin
      sq_xl_q <= SQ_BITS'(loc_i.mag_xl) * SQ_BITS'(loc_i.mag_xl);
      sq_xr_q <= SQ_BITS'(loc_i.mag_xr) * SQ_BITS'(loc_i.mag_xr);
      sq_yb_q <= SQ_BITS'(loc_i.mag_yb) * SQ_BITS'(loc_i.mag_yb);
      sq_yt_q <= SQ_BITS'(loc_i.mag_yt) * SQ_BITS'(loc_i.mag_yt);
      rsq_q   <= SQ_BITS'(loc_i.radius) * SQ_BITS'(loc_i.radius);
      box_q   <= loc_i.box_hit;
      en_q    <= loc_i.disc_en;
    end
  end

  logic [SQ_BITS:0]       rsq_e;
  logic [NUM_CORNERS-1:0] disc_hit;
  logic                   inside_d, inside_q;

  assign rsq_e = (SQ_BITS+1)'(rsq_q);

  assign disc_hit[CORNER_BL] = (SQ_BITS+1)'(sq_xl_q) + (SQ_BITS+1)'(sq_yb_q) <= rsq_e;
  assign disc_hit[CORNER_BR] = (SQ_BITS+1)'(sq_xr_q) + (SQ_BITS+1)'(sq_yb_q) <= rsq_e;
  assign disc_hit[CORNER_TL] = (SQ_BITS+1)'(sq_xl_q) + (SQ_BITS+1)'(sq_yt_q) <= rsq_e;
  assign disc_hit[CORNER_TR] = (SQ_BITS+1)'(sq_xr_q) + (SQ_BITS+1)'(sq_yt_q) <= rsq_e;

  assign inside_d = box_q || |(en_q & disc_hit);

  always_ff @(posedge clk_i) begin
    if (s4_en_i) begin
      inside_q <= inside_d;
    end
  end

  assign inside_o = inside_q;

endmodule

### src/rounded_rect_hit_test.sv
// Channel  Direction  Handshake                 Beat
// in       sink       in_valid_i / in_stall_o   point_x_i, point_y_i
// out      source     out_valid_o / out_stall_i inside_res_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One point per cycle while the output is not stalled; a result is offered once its point
// has passed the four register stages (capture, locate, square, compare).
// Reset clears the stage valid bits and the shape registers to zero.
// Each stage holds its beat only while the stage behind it is full and stalled,
// so in_stall_o rises only once all four stages are full and out_stall_i is high.
module rounded_rect_hit_test import rrht_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned DATA_BITS  = (COORD_BITS > 16) ? COORD_BITS : 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [DATA_BITS-1:0]         cfg_data_i
);

  logic signed [COORD_BITS-1:0] rect_x, rect_y;
  logic [WIDTH_BITS-1:0]        rect_width;
  logic [HEIGHT_BITS-1:0]       rect_height;
  logic [RADIUS_BITS-1:0]       corner_radius;
  loc_t                         loc;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  rrht_cfg #(
    .COORD_BITS (COORD_BITS),
    .DATA_BITS  (DATA_BITS)
  ) u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rect_x_o        (rect_x),
    .rect_y_o        (rect_y),
    .rect_width_o    (rect_width),
    .rect_height_o   (rect_height),
    .corner_radius_o (corner_radius)
  );

  rrht_locate #(
    .COORD_BITS (COORD_BITS)
  ) u_locate (
    .clk_i           (clk_i),
    .s1_en_i         (rdy1 && in_valid_i),
    .s2_en_i         (rdy2 && v1_q),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .rect_x_i        (rect_x),
    .rect_y_i        (rect_y),
    .rect_width_i    (rect_width),
    .rect_height_i   (rect_height),
    .corner_radius_i (corner_radius),
    .loc_o           (loc)
  );

  rrht_disc u_disc (
    .clk_i    (clk_i),
    .s3_en_i  (rdy3 && v2_q),
    .s4_en_i  (rdy4 && v3_q),
    .loc_i    (loc),
    .inside_o (inside_res_o)
  );

endmodule

### sim/rrht_hit_check.sv
`timescale 1ns / 100ps

module rrht_hit_check import rrht_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [15:0]        point_x_i,
  input  logic signed [15:0]        point_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      inside_res_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [15:0]               cfg_data_i,
  output int                        error_count_o,
  output int                        pending_o
);

  typedef struct {
    longint px;
    longint py;
    bit     hit;
  } hit_probe_t;

  hit_probe_t expected_hits[$];

  longint shape_x, shape_y, shape_w, shape_h, shape_r;

  function automatic bit box_covers(longint bx, longint by, longint w, longint h,
                                    longint px, longint py);
    return px >= bx && px <= bx + w && py >= by && py <= by + h;
  endfunction

  function automatic bit disc_covers(longint cx, longint cy, longint r,
                                     longint px, longint py);
    longint dx, dy;
    dx = px - cx;
    dy = py - cy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx > r || dy > r) return 1'b0;
    return dx * dx + dy * dy <= r * r;
  endfunction

  function automatic bit point_inside(longint px, longint py);
    longint x, y, w, h, r;
    bit bl, br, tl, tr;
    x = shape_x;
    y = shape_y;
    w = shape_w;
    h = shape_h;
    r = shape_r;
    if (r == 0) return box_covers(x, y, w, h, px, py);
    bl = disc_covers(x + r, y + r, r, px, py);
    if (2 * r == h && h == w) return bl;
    br = disc_covers(x + w - r, y + r, r, px, py);
    tl = disc_covers(x + r, y + h - r, r, px, py);
    if (2 * r == h) begin
      return box_covers(x + r, y, w - h, h, px, py)
          || (px < x + r && bl) || (px > x + w - r && br);
    end
    if (2 * r == w) begin
      return box_covers(x, y + r, w, h - w, px, py)
          || (py < y + r && bl) || (py > y + h - r && tl);
    end
    tr = disc_covers(x + w - r, y + h - r, r, px, py);
    return box_covers(x + r, y, w - 2 * r, h, px, py)
        || box_covers(x, y + r, r, h - 2 * r, px, py)
        || box_covers(x + w - r, y + r, r, h - 2 * r, px, py)
        || (px < x + r && py < y + r && bl)
        || (px < x + r && py > y + h - r && tl)
        || (px > x + w - r && py < y + r && br)
        || (px > x + w - r && py > y + h - r && tr);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_probe_t probe;
    if (!rst_ni) begin
      shape_x = 0;
      shape_y = 0;
      shape_w = 0;
      shape_h = 0;
      shape_r = 0;
      expected_hits.delete();
      error_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, got inside=%0b",
                   $time, inside_res_i);
          error_count_o++;
        end else begin
          probe = expected_hits.pop_front();
          if (inside_res_i !== probe.hit) begin
            $display("%0t: point (%0d,%0d): expected inside=%0b, got inside=%0b",
                     $time, probe.px, probe.py, probe.hit, inside_res_i);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        probe.px = longint'(point_x_i);
        probe.py = longint'(point_y_i);
        probe.hit = point_inside(probe.px, probe.py);
        expected_hits.push_back(probe);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_RECT_X:        shape_x = longint'($signed(cfg_data_i));
          REG_RECT_Y:        shape_y = longint'($signed(cfg_data_i));
          REG_RECT_WIDTH:    shape_w = longint'(cfg_data_i[14:0]);
          REG_RECT_HEIGHT:   shape_h = longint'(cfg_data_i[14:0]);
          REG_CORNER_RADIUS: shape_r = longint'(cfg_data_i[13:0]);
          default: ;
        endcase
      end
    end
    pending_o = expected_hits.size();
  end

endmodule

### sim/rounded_rect_hit_test_test.sv
`timescale 1ns / 100ps

module rounded_rect_hit_test_test;
  import rrht_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_POINTS = 61;
  localparam int DRAIN_CYCLES  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [15:0]        point_x;
  logic signed [15:0]        point_y;
  logic                      out_valid;
  logic                      out_stall;
  logic                      inside_res;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [15:0]               cfg_data;

  int     error_count;
  int     pending;
  int     tx_idle_pct;
  int     rx_stall_pct;
  int     hold_left;
  bit     hold_request;
  longint cur_x, cur_y, cur_w, cur_h, cur_r;

  rounded_rect_hit_test dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .inside_res_o (inside_res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  rrht_hit_check u_hit_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .inside_res_i  (inside_res),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  // hold off for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic logic [15:0] clamp_coord(longint v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7fff;
    return v[15:0];
  endfunction

  task automatic send_point(longint px, longint py);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    point_x  <= clamp_coord(px);
    point_y  <= clamp_coord(py);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
  endtask

  task automatic set_shape(int x, int y, int w, int h, int r, bit dirty);
    logic [15:0] xd, yd, wd, hd, rd;
    xd = 16'(x);
    yd = 16'(y);
    wd = {1'b0, 15'(w)};
    hd = {1'b0, 15'(h)};
    rd = {2'b00, 14'(r)};
    if (dirty) begin
      wd[15]    = 1'($urandom_range(1));
      hd[15]    = 1'($urandom_range(1));
      rd[15:14] = 2'($urandom_range(3));
    end
    drain();
    write_reg(REG_CORNER_RADIUS, rd);
    write_reg(REG_RECT_X, xd);
    write_reg(REG_RECT_HEIGHT, hd);
    write_reg(REG_RECT_Y, yd);
    write_reg(REG_RECT_WIDTH, wd);
    if (dirty) begin
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
    end
    cur_x = longint'($signed(xd));
    cur_y = longint'($signed(yd));
    cur_w = longint'(wd[14:0]);
    cur_h = longint'(hd[14:0]);
    cur_r = longint'(rd[13:0]);
  endtask

  task automatic probe_outline();
    longint d;
    d = cur_r * 7 / 10;
    send_point(cur_x, cur_y);
    send_point(cur_x - 1, cur_y);
    send_point(cur_x + cur_w, cur_y + cur_h);
    send_point(cur_x + cur_w + 1, cur_y + cur_h);
    send_point(cur_x + cur_r, cur_y);
    send_point(cur_x, cur_y + cur_r);
    send_point(cur_x + cur_w - cur_r, cur_y + cur_h);
    send_point(cur_x + cur_w, cur_y + cur_h - cur_r);
    send_point(cur_x + cur_r - d, cur_y + cur_r - d);
    send_point(cur_x + cur_r - d - 1, cur_y + cur_r - d - 1);
  endtask

  task automatic send_random_point();
    int     sel;
    longint cx, cy, span, px, py;
    sel = $urandom_range(99);
    if (sel < 40) begin
      cx = $urandom_range(1) ? cur_x + cur_r : cur_x + cur_w - cur_r;
      cy = $urandom_range(1) ? cur_y + cur_r : cur_y + cur_h - cur_r;
      span = cur_r + 3;
      px = cx + longint'($urandom_range(2 * span)) - span;
      py = cy + longint'($urandom_range(2 * span)) - span;
    end else if (sel < 80) begin
      px = cur_x - 8 + longint'($urandom_range(cur_w + 16));
      py = cur_y - 8 + longint'($urandom_range(cur_h + 16));
    end else begin
      px = longint'($urandom_range(65535)) - 32768;
      py = longint'($urandom_range(65535)) - 32768;
    end
    send_point(px, py);
  endtask

  task automatic run_phase(int x, int y, int w, int h, int r, bit dirty, int phase_no);
    case (phase_no % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
      default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
    endcase
    set_shape(x, y, w, h, r, dirty);
    probe_outline();
    for (int k = 0; k < RANDOM_POINTS; k++) begin
      if (phase_no == 2 && k == RANDOM_POINTS / 2) hold_request = 1'b1;
      send_random_point();
    end
  endtask

  initial begin
    int rx, ry, rr, rw, rh, mode;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    point_x      = '0;
    point_y      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_RECT_X;
    cfg_data     = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 0;
    hold_request = 1'b0;
    cur_x = 0;
    cur_y = 0;
    cur_w = 0;
    cur_h = 0;
    cur_r = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset shape is a single-point box at the origin
    send_point(0, 0);
    send_point(1, 0);
    send_point(0, -1);
    send_point(-32768, -32768);
    send_point(32767, 32767);
    send_point(-32768, 32767);
    send_point(32767, -32768);
    send_point(16'sh5555, -16'sh5556);

    run_phase(-100, 50, 200, 120, 0, 1'b0, 0);
    run_phase(300, -200, 80, 80, 40, 1'b1, 1);
    run_phase(-50, -30, 200, 60, 30, 1'b0, 2);
    run_phase(10, 20, 50, 170, 25, 1'b0, 3);
    run_phase(-75, 40, 150, 100, 20, 1'b1, 4);
    run_phase(0, 0, 150, 60, 100, 1'b0, 5);
    run_phase(5, -5, 0, 0, 5, 1'b0, 6);
    run_phase(-32768, -32768, 32767, 32767, 16383, 1'b1, 7);
    run_phase(32767, 32767, 32767, 32767, 0, 1'b0, 8);
    run_phase(-16000, -16383, 32767, 32766, 16383, 1'b0, 9);
    run_phase(-16383, -16383, 32766, 32766, 16383, 1'b1, 10);
    run_phase(-16383, -16000, 32766, 32767, 16383, 1'b0, 11);
    for (int n = 0; n < 4; n++) begin
      rx = int'($urandom_range(65535)) - 32768;
      ry = int'($urandom_range(65535)) - 32768;
      rr = $urandom_range(300, 1);
      mode = (n + $urandom_range(3)) % 4;
      case (mode)
        0: begin rw = 2 * rr; rh = 2 * rr; end
        1: begin rh = 2 * rr; rw = $urandom_range(900, 2 * rr + 1); end
        2: begin rw = 2 * rr; rh = $urandom_range(900, 2 * rr + 1); end
        default: begin rw = $urandom_range(900); rh = $urandom_range(900); end
      endcase
      run_phase(rx, ry, rw, rh, rr, n[0], 12 + n);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
